// ===== rtl/cdta_pkg.sv =====
// Shared types, codes and calendar helpers of the date and time adder.
package cdta_pkg;

  // Codes of the function field
  localparam logic [1:0] F_LOAD = 2'd0;
  localparam logic [1:0] F_ADD  = 2'd1;
  localparam logic [1:0] F_SUB  = 2'd2;

  // Codes of the unit field
  localparam logic [2:0] U_SEC   = 3'd0;
  localparam logic [2:0] U_MIN   = 3'd1;
  localparam logic [2:0] U_HOUR  = 3'd2;
  localparam logic [2:0] U_DAY   = 3'd3;
  localparam logic [2:0] U_MONTH = 3'd4;
  localparam logic [2:0] U_YEAR  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_Y400,
    OP_Y400_SET,
    OP_TIME,
    OP_TIME_SET,
    OP_DAY,
    OP_MON,
    OP_MON_SET,
    OP_YEAR,
    OP_CLAMP,
    OP_WDAY,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic       run_ok;    // add or subtract on a valid held date with a known unit
    logic [2:0] unit;
    logic       lvl_day;   // time carry chain has reached days
    logic       sub_small; // subtract fits in the current time field
    logic       div_done;
    logic       day_last;  // this day step finishes the walk
    logic       mon_sat;   // month shift leaves the year range
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    r = 5'd31;
    if (m == 4'd2) begin
      r = lp ? 5'd29 : 5'd28;
    end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      r = 5'd30;
    end
    return r;
  endfunction

  // 3*(m+1)/5 for the weekday sum
  function automatic logic [3:0] wk_month_term(input logic [3:0] m);
    logic [3:0] r;
    unique case (m)
      4'd0:  r = 4'd0;
      4'd1:  r = 4'd1;
      4'd2:  r = 4'd1;
      4'd3:  r = 4'd2;
      4'd4:  r = 4'd3;
      4'd5:  r = 4'd3;
      4'd6:  r = 4'd4;
      4'd7:  r = 4'd4;
      4'd8:  r = 4'd5;
      4'd9:  r = 4'd6;
      4'd10: r = 4'd6;
      4'd11: r = 4'd7;
      4'd12: r = 4'd7;
      4'd13: r = 4'd8;
      4'd14: r = 4'd9;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cdta_dpath.sv =====
// Datapath: held date, carry and borrow arithmetic, shared reciprocal divider, result register.
module cdta_dpath import cdta_pkg::*; #(
  parameter int AW         = 16,
  parameter int YEAR_LIMIT = 9999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic [1:0]    func_i,
  input  logic [2:0]    unit_i,
  input  logic [AW-1:0] amount_i,
  input  logic [13:0]   ld_year_i,
  input  logic [3:0]    ld_month_i,
  input  logic [4:0]    ld_day_i,
  input  logic [4:0]    ld_hour_i,
  input  logic [5:0]    ld_min_i,
  input  logic [5:0]    ld_sec_i,
  output logic [13:0]   out_year_o,
  output logic [3:0]    out_month_o,
  output logic [4:0]    out_day_o,
  output logic [4:0]    out_hour_o,
  output logic [5:0]    out_min_o,
  output logic [5:0]    out_sec_o,
  output logic [2:0]    out_wday_o,
  output logic          out_ok_o
);

  localparam int YLB = $clog2(YEAR_LIMIT + 1);
  localparam int YW  = (YLB > 14) ? YLB : 14;
  localparam int DW  = ((AW > YW + 5) ? AW : YW + 5) + 1;
  localparam int WY  = YW + 1;
  localparam int KSH = DW + 9;
  localparam int MW  = DW + 9;
  localparam int PW  = DW + MW;
  localparam logic [YW-1:0] LIM      = YW'(YEAR_LIMIT);
  localparam logic [8:0]    LIM_R400 = 9'(YEAR_LIMIT % 400);
  localparam logic [DW-1:0] LIM12    = DW'(YEAR_LIMIT * 12 + 11);
  localparam logic [1:0]    DIV_START = 2'd2;
  // rounded-up reciprocals, exact for every dividend below 2**DW
  localparam logic [MW-1:0] M400 = MW'(((64'd1 << KSH) + 64'd399) / 64'd400);
  localparam logic [MW-1:0] M60  = MW'(((64'd1 << KSH) + 64'd59) / 64'd60);
  localparam logic [MW-1:0] M24  = MW'(((64'd1 << KSH) + 64'd23) / 64'd24);
  localparam logic [MW-1:0] M12  = MW'(((64'd1 << KSH) + 64'd11) / 64'd12);
  localparam logic [MW-1:0] M7   = MW'(((64'd1 << KSH) + 64'd6) / 64'd7);

  logic [YW-1:0] yr_q, yr_d;
  logic [3:0]    mo_q, mo_d;
  logic [4:0]    dy_q, dy_d, hr_q, hr_d;
  logic [5:0]    mi_q, mi_d, se_q, se_d;
  logic [DW-1:0] n_q, n_d;
  logic [1:0]    lvl_q, lvl_d, func_q, func_d;
  logic [2:0]    unit_q, unit_d;
  logic          sat_q, sat_d, clamp_q, clamp_d;
  logic [8:0]    r400_q, r400_d;
  logic [YW-1:0] q400_q, q400_d;
  logic [DW-1:0] dq_q, dq_d;
  logic [8:0]    dr_q, dr_d, dd_q, dd_d;
  logic [1:0]    dcnt_q, dcnt_d;
  logic [13:0]   oyr_q, oyr_d;
  logic [3:0]    omo_q, omo_d;
  logic [4:0]    ody_q, ody_d, ohr_q, ohr_d;
  logic [5:0]    omi_q, omi_d, ose_q, ose_d;
  logic [2:0]    owd_q, owd_d;
  logic          ook_q, ook_d;

  logic          leap, hv, up;
  logic [4:0]    ml, pml;
  logic [5:0]    fld, fld_new;
  logic [8:0]    tdiv;
  logic [DW-1:0] gap, tcur, tup;
  logic [PW-1:0] prod;
  logic [DW-1:0] quo;
  logic [8:0]    qd;
  logic          wsh;
  logic [3:0]    wm;
  logic [WY-1:0] wy;
  logic [8:0]    rr;
  logic [YW-1:0] y400;
  logic [YW+1:0] y100;
  logic [1:0]    k100;
  logic [DW-1:0] wsum;

  always_comb begin
    leap = (r400_q[1:0] == 2'd0) && (r400_q != 9'd100) && (r400_q != 9'd200) &&
           (r400_q != 9'd300);
    ml   = month_len(mo_q, leap);
    pml  = (mo_q == 4'd1) ? 5'd31 : month_len(mo_q - 4'd1, leap);
    hv   = (yr_q <= LIM) && (mo_q >= 4'd1) && (mo_q <= 4'd12) && (dy_q != 5'd0) &&
           (dy_q <= ml) && (hr_q <= 5'd23) && (mi_q <= 6'd59) && (se_q <= 6'd59);
    up   = (func_q == F_ADD);

    unique case (lvl_q)
      2'd0:    fld = se_q;
      2'd1:    fld = mi_q;
      default: fld = {1'b0, hr_q};
    endcase
    tdiv = (lvl_q == 2'd2) ? 9'd24 : 9'd60;

    gap  = DW'(ml - dy_q);
    tcur = (DW'(yr_q) << 3) + (DW'(yr_q) << 2) + DW'(mo_q - 4'd1);
    tup  = tcur + n_q;

    // quotient by reciprocal multiplication, remainder from the low bits
    unique case (dd_q)
      9'd400:  prod = PW'(dq_q) * PW'(M400);
      9'd60:   prod = PW'(dq_q) * PW'(M60);
      9'd24:   prod = PW'(dq_q) * PW'(M24);
      9'd12:   prod = PW'(dq_q) * PW'(M12);
      default: prod = PW'(dq_q) * PW'(M7);
    endcase
    quo = prod[KSH +: DW];
    qd  = 9'(dq_q[8:0] * dd_q);

    // weekday sum, January and February as months 13 and 14 of the year before
    wsh  = (mo_q == 4'd1) || (mo_q == 4'd2);
    wm   = wsh ? (mo_q + 4'd12) : mo_q;
    wy   = WY'(yr_q) + WY'(400) - WY'(wsh);
    rr   = r400_q - 9'(wsh);
    if (r400_q >= 9'(wsh)) begin
      y400 = q400_q + YW'(1);
      if (rr >= 9'd300)      k100 = 2'd3;
      else if (rr >= 9'd200) k100 = 2'd2;
      else if (rr >= 9'd100) k100 = 2'd1;
      else                   k100 = 2'd0;
    end else begin
      y400 = q400_q;
      k100 = 2'd3;
    end
    y100 = {y400, 2'b00} + (YW+2)'(k100);
    wsum = DW'(dy_q) + DW'({wm, 1'b0}) + DW'(wk_month_term(wm)) + DW'(wy) +
           DW'(wy >> 2) + DW'(y400) - DW'(y100);

    sts_o.run_ok    = ((func_q == F_ADD) || (func_q == F_SUB)) && (unit_q <= U_YEAR) && hv;
    sts_o.unit      = unit_q;
    sts_o.lvl_day   = (lvl_q == 2'd3);
    sts_o.sub_small = !up && (n_q <= DW'(fld));
    sts_o.div_done  = (dcnt_q == '0);
    sts_o.day_last  = up ? ((n_q <= gap) || ((mo_q == 4'd12) && (yr_q >= LIM)))
                         : ((n_q < DW'(dy_q)) || ((mo_q == 4'd1) && (yr_q == '0)));
    sts_o.mon_sat   = up ? (tup > LIM12) : (n_q > tcur);
  end

  always_comb begin
    yr_d = yr_q; mo_d = mo_q; dy_d = dy_q; hr_d = hr_q; mi_d = mi_q; se_d = se_q;
    n_d = n_q; lvl_d = lvl_q; func_d = func_q; unit_d = unit_q;
    sat_d = sat_q; clamp_d = clamp_q; r400_d = r400_q; q400_d = q400_q;
    oyr_d = oyr_q; omo_d = omo_q; ody_d = ody_q; ohr_d = ohr_q; omi_d = omi_q;
    ose_d = ose_q; owd_d = owd_q; ook_d = ook_q;
    dd_d = dd_q;
    fld_new = fld;

    // divider: quotient in the first step, remainder in the second
    unique case (dcnt_q)
      2'd2: begin
        dq_d = quo; dr_d = dq_q[8:0]; dcnt_d = 2'd1;
      end
      2'd1: begin
        dq_d = dq_q; dr_d = dr_q - qd; dcnt_d = 2'd0;
      end
      default: begin
        dq_d = dq_q; dr_d = dr_q; dcnt_d = dcnt_q;
      end
    endcase

    unique case (cmd_i.op)
      OP_LOAD: begin
        if (func_i == F_LOAD) begin
          yr_d = YW'(ld_year_i); mo_d = ld_month_i; dy_d = ld_day_i;
          hr_d = ld_hour_i; mi_d = ld_min_i; se_d = ld_sec_i;
        end
        func_d = func_i; unit_d = unit_i; lvl_d = unit_i[1:0];
        n_d = DW'(amount_i); sat_d = 1'b0; clamp_d = 1'b0;
      end
      OP_Y400: begin
        dq_d = DW'(yr_q); dr_d = '0; dd_d = 9'd400; dcnt_d = DIV_START;
      end
      OP_Y400_SET: begin
        r400_d = dr_q; q400_d = dq_q[YW-1:0];
      end
      OP_TIME: begin
        if (sts_o.sub_small) begin
          fld_new = 6'(fld - n_q[5:0]);
        end else begin
          dq_d = up ? (DW'(fld) + n_q) : (n_q - DW'(fld));
          dr_d = '0; dd_d = tdiv; dcnt_d = DIV_START;
        end
      end
      OP_TIME_SET: begin
        if (up) begin
          fld_new = dr_q[5:0]; n_d = dq_q;
        end else begin
          fld_new = (dr_q == '0) ? 6'd0 : 6'(tdiv - dr_q);
          n_d = dq_q + DW'(dr_q != '0);
        end
        lvl_d = lvl_q + 2'd1;
      end
      OP_DAY: begin
        if (up) begin
          if (n_q <= gap) begin
            dy_d = dy_q + n_q[4:0];
          end else if ((mo_q == 4'd12) && (yr_q >= LIM)) begin
            yr_d = LIM; mo_d = 4'd12; dy_d = 5'd31; hr_d = 5'd23; mi_d = 6'd59;
            se_d = 6'd59; sat_d = 1'b1; r400_d = LIM_R400;
          end else begin
            n_d = n_q - gap - DW'(1); dy_d = 5'd1;
            if (mo_q >= 4'd12) begin
              mo_d = 4'd1; yr_d = yr_q + YW'(1);
              r400_d = (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
            end else begin
              mo_d = mo_q + 4'd1;
            end
          end
        end else begin
          if (n_q < DW'(dy_q)) begin
            dy_d = dy_q - n_q[4:0];
          end else if ((mo_q == 4'd1) && (yr_q == '0)) begin
            yr_d = '0; mo_d = 4'd1; dy_d = 5'd1; hr_d = '0; mi_d = '0; se_d = '0;
            sat_d = 1'b1; r400_d = '0;
          end else begin
            n_d = n_q - DW'(dy_q); dy_d = pml;
            if (mo_q > 4'd1) begin
              mo_d = mo_q - 4'd1;
            end else begin
              mo_d = 4'd12; yr_d = yr_q - YW'(1);
              r400_d = (r400_q == 9'd0) ? 9'd399 : r400_q - 9'd1;
            end
          end
        end
      end
      OP_MON: begin
        if (!sts_o.mon_sat) begin
          dq_d = up ? tup : (tcur - n_q);
          dr_d = '0; dd_d = 9'd12; dcnt_d = DIV_START;
        end else if (up) begin
          yr_d = LIM; mo_d = 4'd12; dy_d = 5'd31; hr_d = 5'd23; mi_d = 6'd59;
          se_d = 6'd59; sat_d = 1'b1;
        end else begin
          yr_d = '0; mo_d = 4'd1; dy_d = 5'd1; hr_d = '0; mi_d = '0; se_d = '0;
          sat_d = 1'b1;
        end
      end
      OP_MON_SET: begin
        yr_d = dq_q[YW-1:0]; mo_d = dr_q[3:0] + 4'd1; clamp_d = 1'b1;
      end
      OP_YEAR: begin
        if (up) begin
          if ((DW'(yr_q) + n_q) > DW'(LIM)) begin
            yr_d = LIM; mo_d = 4'd12; dy_d = 5'd31; hr_d = 5'd23; mi_d = 6'd59;
            se_d = 6'd59; sat_d = 1'b1;
          end else begin
            yr_d = yr_q + n_q[YW-1:0]; clamp_d = 1'b1;
          end
        end else begin
          if (n_q > DW'(yr_q)) begin
            yr_d = '0; mo_d = 4'd1; dy_d = 5'd1; hr_d = '0; mi_d = '0; se_d = '0;
            sat_d = 1'b1;
          end else begin
            yr_d = yr_q - n_q[YW-1:0]; clamp_d = 1'b1;
          end
        end
      end
      OP_CLAMP: begin
        if (clamp_q && (dy_q > ml)) dy_d = ml;
      end
      OP_WDAY: begin
        dq_d = wsum; dr_d = '0; dd_d = 9'd7; dcnt_d = DIV_START;
      end
      OP_OUT: begin
        oyr_d = yr_q[13:0]; omo_d = mo_q; ody_d = dy_q; ohr_d = hr_q; omi_d = mi_q;
        ose_d = se_q; ook_d = hv && !sat_q; owd_d = dr_q[2:0] + 3'd1;
      end
      default: ;
    endcase

    if ((cmd_i.op == OP_TIME) || (cmd_i.op == OP_TIME_SET)) begin
      unique case (lvl_q)
        2'd0:    se_d = fld_new;
        2'd1:    mi_d = fld_new;
        default: hr_d = fld_new[4:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yr_q <= '0; mo_q <= 4'd1; dy_q <= 5'd1; hr_q <= '0; mi_q <= '0; se_q <= '0;
      n_q <= '0; lvl_q <= '0; func_q <= '0; unit_q <= '0; sat_q <= 1'b0;
      clamp_q <= 1'b0; r400_q <= '0; q400_q <= '0;
      dq_q <= '0; dr_q <= '0; dd_q <= 9'd1; dcnt_q <= '0;
      oyr_q <= '0; omo_q <= '0; ody_q <= '0; ohr_q <= '0; omi_q <= '0; ose_q <= '0;
      owd_q <= 3'd1; ook_q <= 1'b0;
    end else begin
      yr_q <= yr_d; mo_q <= mo_d; dy_q <= dy_d; hr_q <= hr_d; mi_q <= mi_d; se_q <= se_d;
      n_q <= n_d; lvl_q <= lvl_d; func_q <= func_d; unit_q <= unit_d; sat_q <= sat_d;
      clamp_q <= clamp_d; r400_q <= r400_d; q400_q <= q400_d;
      dq_q <= dq_d; dr_q <= dr_d; dd_q <= dd_d; dcnt_q <= dcnt_d;
      oyr_q <= oyr_d; omo_q <= omo_d; ody_q <= ody_d; ohr_q <= ohr_d; omi_q <= omi_d;
      ose_q <= ose_d; owd_q <= owd_d; ook_q <= ook_d;
    end
  end

  assign out_year_o  = oyr_q;
  assign out_month_o = omo_q;
  assign out_day_o   = ody_q;
  assign out_hour_o  = ohr_q;
  assign out_min_o   = omi_q;
  assign out_sec_o   = ose_q;
  assign out_wday_o  = owd_q;
  assign out_ok_o    = ook_q;

endmodule

// ===== rtl/cdta_ctrl.sv =====
// Controller: sequences load, carry and borrow passes, divisions and result hand-off.
module cdta_ctrl import cdta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_YS   = 15'b000000000000010,
    S_YW   = 15'b000000000000100,
    S_CHK  = 15'b000000000001000,
    S_TS   = 15'b000000000010000,
    S_TW   = 15'b000000000100000,
    S_DAY  = 15'b000000001000000,
    S_MCK  = 15'b000000010000000,
    S_MW   = 15'b000000100000000,
    S_YR   = 15'b000001000000000,
    S_ES   = 15'b000010000000000,
    S_EW   = 15'b000100000000000,
    S_CLP  = 15'b001000000000000,
    S_WS   = 15'b010000000000000,
    S_WW   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD; state_d = S_YS;
        end
      end
      S_YS: begin
        cmd_o.op = OP_Y400; state_d = S_YW;
      end
      S_YW: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_Y400_SET; state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts_i.run_ok) begin
          state_d = S_CLP;
        end else begin
          unique case (sts_i.unit)
            U_SEC, U_MIN, U_HOUR: state_d = S_TS;
            U_DAY:                state_d = S_DAY;
            U_MONTH:              state_d = S_MCK;
            default:              state_d = S_YR;
          endcase
        end
      end
      S_TS: begin
        if (sts_i.lvl_day) begin
          state_d = S_DAY;
        end else begin
          cmd_o.op = OP_TIME;
          state_d  = sts_i.sub_small ? S_ES : S_TW;
        end
      end
      S_TW: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_TIME_SET; state_d = S_TS;
        end
      end
      S_DAY: begin
        cmd_o.op = OP_DAY;
        if (sts_i.day_last) state_d = S_ES;
      end
      S_MCK: begin
        cmd_o.op = OP_MON;
        state_d  = sts_i.mon_sat ? S_ES : S_MW;
      end
      S_MW: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_MON_SET; state_d = S_ES;
        end
      end
      S_YR: begin
        cmd_o.op = OP_YEAR; state_d = S_ES;
      end
      S_ES: begin
        cmd_o.op = OP_Y400; state_d = S_EW;
      end
      S_EW: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_Y400_SET; state_d = S_CLP;
        end
      end
      S_CLP: begin
        cmd_o.op = OP_CLAMP; state_d = S_WS;
      end
      S_WS: begin
        cmd_o.op = OP_WDAY; state_d = S_WW;
      end
      S_WW: begin
        if (sts_i.div_done && (!ovalid_q || out_ready_i)) begin
          cmd_o.op = OP_OUT; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    ovalid_d = (ovalid_q && !out_ready_i) || (cmd_o.op == OP_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> sts_i.div_done) else $error("divider busy while idle");
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_WW)) else $error("result raised early");
  a_day_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DAY) && sts_i.day_last |=> (state_q == S_ES))
    else $error("day walk did not end");
`endif

endmodule

// ===== rtl/calendar_date_time_adder_core.sv =====
// Top level of the Gregorian date and time adder: stream ports, controller and datapath.
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+------------------------------------------------------------------
//  s_axis   | in  | tuser: func, unit; tdata: amount, load year/month/day/hour/min/sec
//  m_axis   | out | tuser: date_ok; tdata: year, month, day, hour, minute, second,
//           |     |        weekday
//
// One transaction at a time. Each item runs a division by 400 (leap phase of the year)
// and one by 7 for the weekday on the shared reciprocal divider, each a quotient step
// and a remainder step. A valid add or subtract adds a second division by 400 after
// its operation: a division by 60 or 24 per carry level of seconds, minutes and hours,
// one day walk step per month crossed (up to a few thousand for large day amounts), a
// division by 12 for a month shift and a single step for a year shift.
// Reset puts the held date at 0000-01-01 00:00:00 and empties the result register.
// A result waits in its register until m_axis_tready; the next item is taken meanwhile
// and holds in its last cycle until the register frees.
module calendar_date_time_adder_core import cdta_pkg::*; #(
  parameter int AMOUNT_WIDTH = 16,
  parameter int YEAR_LIMIT   = 9999
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // amount, load_year, load_month, load_day, load_hour, load_minute, load_second
  input  logic [((AMOUNT_WIDTH+40+7)/8)*8-1:0] s_axis_tdata,
  // func, unit
  input  logic [4:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_year, out_month, out_day, out_hour, out_minute, out_second, weekday
  output logic [47:0]           m_axis_tdata,
  // date_ok
  output logic [0:0]            m_axis_tuser
);

  localparam int AW = AMOUNT_WIDTH;

  cmd_t        cmd;
  sts_t        sts;
  logic [13:0] oyr;
  logic [3:0]  omo;
  logic [4:0]  ody, ohr;
  logic [5:0]  omi, ose;
  logic [2:0]  owd;
  logic        ook;

  cdta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdta_dpath #(
    .AW         (AW),
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (s_axis_tuser[1:0]),
    .unit_i      (s_axis_tuser[4:2]),
    .amount_i    (s_axis_tdata[AW-1:0]),
    .ld_year_i   (s_axis_tdata[AW+13:AW]),
    .ld_month_i  (s_axis_tdata[AW+17:AW+14]),
    .ld_day_i    (s_axis_tdata[AW+22:AW+18]),
    .ld_hour_i   (s_axis_tdata[AW+27:AW+23]),
    .ld_min_i    (s_axis_tdata[AW+33:AW+28]),
    .ld_sec_i    (s_axis_tdata[AW+39:AW+34]),
    .out_year_o  (oyr),
    .out_month_o (omo),
    .out_day_o   (ody),
    .out_hour_o  (ohr),
    .out_min_o   (omi),
    .out_sec_o   (ose),
    .out_wday_o  (owd),
    .out_ok_o    (ook)
  );

  // pack result fields, pad to whole bytes
  assign m_axis_tdata = {5'd0, owd, ose, omi, ohr, ody, omo, oyr};
  assign m_axis_tuser = ook;

endmodule
